// ----- hdl/sha256_byte_stream_hasher_macros.svh -----
// Assertion macros shared by the SHA-256 hasher checker.
`ifndef SHA256_BYTE_STREAM_HASHER_MACROS_SVH
`define SHA256_BYTE_STREAM_HASHER_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define SHA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Implication checked in the cycle after the antecedent.
`define SHA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- hdl/sha_pkg.sv -----
// Types, constants and round functions for the SHA-256 hasher.
package sha_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } sha_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        last_word;
  } sha_out_t;

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenStart = 6'd56;

  typedef enum logic [3:0] {
    ST_INIT,    // write initial hash into chaining memory
    ST_IDLE,    // take bytes
    ST_PAD,     // append 0x80 and zeros
    ST_LEN,     // append bit length bytes
    ST_LOADH,   // read chaining words into working registers
    ST_ROUND,   // 64 rounds
    ST_ADDH,    // add working registers back into chaining memory
    ST_EMIT     // send digest words
  } sha_state_t;

  // Control from the sequencer to the block buffer.
  typedef struct packed {
    logic       wr_en;
    logic [5:0] wr_addr;
    logic [7:0] wr_data;
    logic [3:0] rd_word;
  } sha_buf_ctl_t;

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
      32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
      32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
      32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
      32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
      32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
      32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
      32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
      32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
      32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
      32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
    return k[t];
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] i);
    logic [31:0] h [8];
    h = '{32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
          32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};
    return h[i];
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ----- hdl/sha256_byte_stream_hasher.sv -----
// Top level of the SHA-256 byte-stream hasher.
// Takes one message byte per transfer and returns the SHA-256 digest as
// eight 32-bit words (H0 first) after a transfer with end_of_message set.
// Data bytes are taken back to back while idle; the 64th byte of a block
// starts a compression (the rounds, then chain-word read and write-back
// through the chaining memory), during which in_ready is low.
// Finalizing writes the pad and length bytes one per cycle, pausing for
// the one or two compressions it needs, then the digest words leave one
// per output transfer from a registered output stage. After reset, and
// again after each digest, the chaining memory is loaded with the eight
// initial hash values before the next byte is taken. The chaining words
// live in an 8-entry memory that is read one word per cycle (registered
// read) and written back after each block.
module sha256_byte_stream_hasher
  import sha_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  sha_in_t  in_data,
  input  logic     in_valid,
  output logic     in_ready,
  output sha_out_t out_data,
  output logic     out_valid,
  input  logic     out_ready
);

  sha_state_t   state, state_next;
  sha_state_t   ret_state, ret_state_next;   // where to go after compression
  logic [5:0]   fill, fill_next;
  logic [63:0]  byte_count, byte_count_next;
  logic [6:0]   cnt, cnt_next;               // round / word counter
  logic         final_done, final_done_next; // 0x80 pad byte already written
  sha_buf_ctl_t bctl;
  logic [31:0]  blk_word;

  // chaining memory
  logic [31:0]  hmem [8];
  logic         h_we;
  logic [2:0]   h_waddr, h_raddr;
  logic [31:0]  h_wdata, h_rdata;

  logic [31:0]  work [8];
  logic         r_load, r_step;

  logic         accept;
  logic [63:0]  bits;
  logic         emit_load;

  always_ff @(posedge clk) begin
    if (h_we) hmem[h_waddr] <= h_wdata;
    h_rdata <= hmem[h_raddr];
  end

  sha_block_buf u_buf (.clk(clk), .ctl(bctl), .rd_data(blk_word));

  sha_round u_round (
    .clk(clk), .load(r_load), .load_idx(cnt[2:0] - 3'd1), .load_data(h_rdata),
    .step(r_step), .t(cnt[5:0]), .blk_word(blk_word), .work(work)
  );

  assign accept = in_valid && in_ready;
  assign bits   = {byte_count[60:0], 3'b000};

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      ret_state  <= ST_IDLE;
      fill       <= '0;
      byte_count <= '0;
      cnt        <= '0;
      final_done <= 1'b0;
    end else begin
      state      <= state_next;
      ret_state  <= ret_state_next;
      fill       <= fill_next;
      byte_count <= byte_count_next;
      cnt        <= cnt_next;
      final_done <= final_done_next;
    end
  end

  // Output register: holds one digest word until transferred.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Emit reads the chain word ahead of the output load: cnt counts reads issued.
  assign emit_load = (state == ST_EMIT) && cnt >= 7'd1 && cnt <= 7'd8 &&
                     (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_data.digest_word <= h_rdata;
      out_data.word_number <= cnt[2:0] - 3'd1;
      out_data.last_word   <= (cnt == 7'd8);
    end
  end

  always_comb begin
    state_next      = state;
    ret_state_next  = ret_state;
    fill_next       = fill;
    byte_count_next = byte_count;
    cnt_next        = cnt;
    final_done_next = final_done;
    in_ready        = 1'b0;
    bctl            = '{wr_en: 1'b0, wr_addr: fill, wr_data: in_data.data_byte,
                        rd_word: cnt[3:0]};
    h_we            = 1'b0;
    h_waddr         = cnt[2:0];
    h_wdata         = init_h(cnt[2:0]);
    h_raddr         = cnt[2:0];
    r_load          = 1'b0;
    r_step          = 1'b0;

    case (state)
      ST_INIT: begin
        h_we     = 1'b1;
        cnt_next = cnt + 7'd1;
        if (cnt == 7'd7) begin
          cnt_next   = '0;
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          if (in_data.byte_present) begin
            bctl.wr_en      = 1'b1;
            fill_next       = fill + 6'd1;
            byte_count_next = byte_count + 64'd1;
          end
          if (in_data.byte_present && fill == 6'd63) begin
            cnt_next       = '0;
            ret_state_next = in_data.end_of_message ? ST_PAD : ST_IDLE;
            state_next     = ST_LOADH;
          end else if (in_data.end_of_message) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        // first pad write is 0x80, then zeros until the length slot
        bctl.wr_en   = 1'b1;
        bctl.wr_data = final_done ? 8'h00 : PadByte;
        final_done_next = 1'b1;
        fill_next    = fill + 6'd1;
        if (fill == 6'd63) begin
          cnt_next       = '0;
          ret_state_next = ST_PAD;
          state_next     = ST_LOADH;
        end else if (fill == LenStart - 6'd1) begin
          state_next = ST_LEN;
        end
      end
      ST_LEN: begin
        bctl.wr_en   = 1'b1;
        bctl.wr_data = bits[(7 - fill[2:0]) * 8 +: 8];
        fill_next    = fill + 6'd1;
        if (fill == 6'd63) begin
          cnt_next       = '0;
          ret_state_next = ST_EMIT;
          state_next     = ST_LOADH;
        end
      end
      ST_LOADH: begin
        // read chain word cnt, load it in the next cycle; block word 0 prefetch
        h_raddr  = cnt[2:0];
        r_load   = (cnt != 7'd0);
        bctl.rd_word = 4'd0;
        cnt_next = cnt + 7'd1;
        if (cnt == 7'd8) begin
          cnt_next     = '0;
          bctl.rd_word = 4'd0;
          state_next   = ST_ROUND;
        end
      end
      ST_ROUND: begin
        // blk_word holds word cnt (read issued last cycle); prefetch cnt+1
        r_step       = 1'b1;
        bctl.rd_word = cnt[3:0] + 4'd1;
        h_raddr      = 3'd0;
        cnt_next     = cnt + 7'd1;
        if (cnt == 7'd63) begin
          cnt_next   = '0;
          state_next = ST_ADDH;
        end
      end
      ST_ADDH: begin
        // cnt 0 issues read of H0; cnt k writes H[k-1] + work[k-1]
        h_raddr  = cnt[2:0];
        h_waddr  = cnt[2:0] - 3'd1;
        h_wdata  = h_rdata + work[cnt[2:0] - 3'd1];
        h_we     = (cnt != 7'd0);
        cnt_next = cnt + 7'd1;
        if (cnt == 7'd8) begin
          cnt_next   = '0;
          state_next = ret_state;
        end
      end
      ST_EMIT: begin
        // cnt 0 issues read of H0; each output load issues the next read
        h_raddr = cnt[2:0];
        if (cnt == 7'd0) begin
          cnt_next = 7'd1;
        end else if (emit_load) begin
          cnt_next = cnt + 7'd1;
          h_raddr  = cnt[2:0];
          if (cnt == 7'd8) begin
            cnt_next        = '0;
            fill_next       = '0;
            byte_count_next = '0;
            final_done_next = 1'b0;
            state_next      = ST_INIT;
          end
        end else begin
          h_raddr = cnt[2:0] - 3'd1;
        end
      end
      default: state_next = ST_INIT;
    endcase
  end

endmodule

// ----- hdl/sha_block_buf.sv -----
// Byte-wide block memory, read back as 32-bit words for the schedule.
module sha_block_buf
  import sha_pkg::*;
(
  input  logic         clk,
  input  sha_buf_ctl_t ctl,
  output logic [31:0]  rd_data
);

  logic [7:0] mem0 [16];
  logic [7:0] mem1 [16];
  logic [7:0] mem2 [16];
  logic [7:0] mem3 [16];

  // byte lane = addr[1:0], big-endian within a word
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      case (ctl.wr_addr[1:0])
        2'd0: mem0[ctl.wr_addr[5:2]] <= ctl.wr_data;
        2'd1: mem1[ctl.wr_addr[5:2]] <= ctl.wr_data;
        2'd2: mem2[ctl.wr_addr[5:2]] <= ctl.wr_data;
        default: mem3[ctl.wr_addr[5:2]] <= ctl.wr_data;
      endcase
    end
    rd_data <= {mem0[ctl.rd_word], mem1[ctl.rd_word], mem2[ctl.rd_word],
                mem3[ctl.rd_word]};
  end

endmodule

// ----- hdl/sha_round.sv -----
// Message schedule window and one compression round per cycle in which step is high.
module sha_round
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        load,      // load a..h from chain words
  input  logic [2:0]  load_idx,
  input  logic [31:0] load_data,
  input  logic        step,      // run one round
  input  logic [5:0]  t,
  input  logic [31:0] blk_word,  // schedule word for t < 16
  output logic [31:0] work [8]
);

  logic [31:0] w [16];
  logic [31:0] wt, s0, s1, t1, t2, e, a;

  always_comb begin
    s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    wt = (t < 6'd16) ? blk_word : (w[0] + s0 + w[9] + s1);
    e  = work[4];
    a  = work[0];
    t1 = work[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) +
         ((e & work[5]) ^ (~e & work[6])) + round_k(t) + wt;
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) +
         ((a & work[1]) ^ (a & work[2]) ^ (work[1] & work[2]));
  end

  always_ff @(posedge clk) begin
    if (load) begin
      work[load_idx] <= load_data;
    end else if (step) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15]   <= wt;
      work[7] <= work[6];
      work[6] <= work[5];
      work[5] <= work[4];
      work[4] <= work[3] + t1;
      work[3] <= work[2];
      work[2] <= work[1];
      work[1] <= work[0];
      work[0] <= t1 + t2;
    end
  end

endmodule

// ----- hdl/sha_checker.sv -----
// Port-level checker for the SHA-256 hasher, bound to the top level.
`include "sha256_byte_stream_hasher_macros.svh"
module sha_checker
  import sha_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input sha_in_t  in_data,
  input logic     in_valid,
  input logic     in_ready,
  input sha_out_t out_data,
  input logic     out_valid,
  input logic     out_ready
);

  `SHA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "output dropped while stalled")
  `SHA_ASSERT_NEXT(a_word_seq, out_valid && out_ready && !out_data.last_word, out_data.word_number == $past(out_data.word_number) + 3'd1 || !out_valid, "digest word order broken")
  `SHA_ASSERT_IMP(a_last_flag, out_valid, out_data.last_word == (out_data.word_number == 3'd7), "last_word mismatch")

endmodule

bind sha256_byte_stream_hasher sha_checker u_sha_checker (.*);
